FILE: hdl/hva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hva_pkg
// Shared types and constants of the Hough vote accumulator: sizes of the
// R-table and the accumulator, mode and register codes, sequencer states.
// ----------------------------------------------------------------------------
package hva_pkg;

    localparam int NUM_SLICES   = 64;
    localparam int BUCKET_DEPTH = 64;
    localparam int MAX_WIDTH    = 512;
    localparam int MAX_HEIGHT   = 512;

    localparam int SLW     = $clog2(NUM_SLICES);
    localparam int BW      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FW      = $clog2(BUCKET_DEPTH + 1);
    localparam int TAB_AW  = SLW + BW;
    localparam int TAB_DEPTH = 2 ** TAB_AW;
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int CELL_AW = XW + YW;
    localparam int CELL_DEPTH = 2 ** CELL_AW;
    localparam int CW      = 12;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD      = 2'd0,
        MODE_VOTE      = 2'd1,
        MODE_CLR_VOTES = 2'd2,
        MODE_CLR_TABLE = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL_RD,
        ST_FILL_DAT,
        ST_TAB_RD,
        ST_TAB_DAT,
        ST_CELL_RD,
        ST_CELL_DAT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [9:0] width;
        logic [9:0] height;
    } t_dims;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic                 in_image;
        logic [15:0]          next_count;
        logic                 beats_best;
    } t_vote_eval;

endpackage

FILE: hdl/hva_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hva_ram
// Generic simple dual-port RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
module hva_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/hva_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hva_apb_regs
// APB register file holding the image size, with the size clamped to the
// accumulator dimensions.
// ----------------------------------------------------------------------------
module hva_apb_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output hva_pkg::t_dims       o_dims
);

    logic [9:0] r_width;
    logic [9:0] r_height;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 10'd512;
            r_height <= 10'd512;
        end else if (w_wr) begin
            if (paddr[2] == hva_pkg::REG_WIDTH) begin
                r_width <= pwdata[9:0];
            end else begin
                r_height <= pwdata[9:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == hva_pkg::REG_HEIGHT) begin
            prdata = {22'd0, r_height};
        end else begin
            prdata = {22'd0, r_width};
        end
        o_dims.width  = (32'(r_width) > hva_pkg::MAX_WIDTH) ?
                        10'(hva_pkg::MAX_WIDTH) : r_width;
        o_dims.height = (32'(r_height) > hva_pkg::MAX_HEIGHT) ?
                        10'(hva_pkg::MAX_HEIGHT) : r_height;
    end

endmodule

FILE: hdl/hva_vote_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hva_vote_unit
// Shared arithmetic of one vote step: the target cell and its bounds test,
// then the saturating increment and the compare against the best count.
// ----------------------------------------------------------------------------
module hva_vote_unit (
    input  logic [8:0]             i_px,
    input  logic [8:0]             i_py,
    input  logic [19:0]            i_entry,
    input  hva_pkg::t_dims         i_dims,
    input  logic [15:0]            i_count,
    input  logic [15:0]            i_best,
    output hva_pkg::t_vote_eval    o_eval
);

    localparam int CW = hva_pkg::CW;

    logic signed [CW-1:0] w_px;
    logic signed [CW-1:0] w_py;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [CW-1:0] w_w;
    logic signed [CW-1:0] w_h;

    always_comb begin
        w_px = $signed({{(CW-9){1'b0}}, i_px});
        w_py = $signed({{(CW-9){1'b0}}, i_py});
        w_dx = CW'($signed(i_entry[9:0]));
        w_dy = CW'($signed(i_entry[19:10]));
        w_w  = $signed({{(CW-10){1'b0}}, i_dims.width});
        w_h  = $signed({{(CW-10){1'b0}}, i_dims.height});

        o_eval.cx       = w_px + w_dx;
        o_eval.cy       = w_py + w_dy;
        o_eval.in_image = (o_eval.cx >= 0) && (o_eval.cx < w_w) &&
                          (o_eval.cy >= 0) && (o_eval.cy < w_h);

        o_eval.next_count = (i_count == hva_pkg::COUNT_MAX) ? i_count :
                            i_count + 16'd1;
        o_eval.beats_best = o_eval.next_count > i_best;
    end

endmodule

FILE: hdl/hough_vote_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hough_vote_accumulator
// Generalized Hough voting engine with an R-table of offsets per gradient
// slice and a saturating accumulator over the image plane.
//
// Channel   Direction  Handshake                Payload
// s_axis    in         s_axis_tvalid/tready     tuser mode, tdata item fields
// m_axis    out        m_axis_tvalid/tready     tuser status, tdata result
// apb       in         psel/penable/pready      image_width, image_height
//
// A load transaction steps through the fill read and fill data states to
// the done state; a clear-table transaction goes straight to the done state.
// A vote reads the bucket fill, then the table entry of each offset, and for
// each in-bounds offset does an accumulator read-modify-write.
// After reset and for each clear-votes transaction a clearing pass writes all
// 262144 accumulator cells, one per cycle, while s_axis_tready stays low.
// A waiting result holds the sequencer only when the next result is ready.
// ----------------------------------------------------------------------------
module hough_vote_accumulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Fields from bit 0: pixel_x[8:0], pixel_y[8:0], slice[5:0],
    // offset_x[9:0], offset_y[9:0], zero padding.
    input  logic [47:0] s_axis_tdata,
    // Fields from bit 0: mode[1:0].
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: votes_cast[6:0], best_x[8:0], best_y[8:0],
    // best_hits[15:0], zero padding.
    output logic [47:0] m_axis_tdata,
    // Fields from bit 0: status.
    output logic        m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLW     = hva_pkg::SLW;
    localparam int BW      = hva_pkg::BW;
    localparam int FW      = hva_pkg::FW;
    localparam int XW      = hva_pkg::XW;
    localparam int YW      = hva_pkg::YW;
    localparam int CELL_AW = hva_pkg::CELL_AW;
    localparam int CW      = hva_pkg::CW;

    hva_pkg::t_state      r_state, n_state;
    hva_pkg::t_mode       r_mode, n_mode;
    logic [8:0]           r_px, n_px;
    logic [8:0]           r_py, n_py;
    logic [SLW-1:0]       r_sl, n_sl;
    logic                 r_sl_ok, n_sl_ok;
    logic [19:0]          r_entry, n_entry;
    logic [FW-1:0]        r_count, n_count;
    logic [BW-1:0]        r_idx, n_idx;
    logic signed [CW-1:0] r_cx, n_cx;
    logic signed [CW-1:0] r_cy, n_cy;
    logic                 r_status, n_status;
    logic [6:0]           r_cast, n_cast;
    logic [8:0]           r_best_x, n_best_x;
    logic [8:0]           r_best_y, n_best_y;
    logic [15:0]          r_best_cnt, n_best_cnt;
    logic [CELL_AW-1:0]   r_clr_addr, n_clr_addr;
    logic                 r_clr_item, n_clr_item;
    logic [hva_pkg::NUM_SLICES-1:0] r_fill_vld, n_fill_vld;
    logic                 r_out_vld, n_out_vld;
    logic                 r_out_status, n_out_status;
    logic [6:0]           r_out_cast, n_out_cast;
    logic [8:0]           r_out_bx, n_out_bx;
    logic [8:0]           r_out_by, n_out_by;
    logic [15:0]          r_out_bh, n_out_bh;

    hva_pkg::t_dims       w_dims;
    hva_pkg::t_vote_eval  w_eval;
    logic [5:0]           w_in_slice;
    logic [FW-1:0]        w_fill_rdata;
    logic [FW-1:0]        w_fill;
    logic                 w_full;
    logic                 w_last;
    logic [19:0]          w_tab_rdata;
    logic [15:0]          w_cell_rdata;
    logic                 w_tab_we;
    logic                 w_fill_we;
    logic                 w_cell_we;
    logic [CELL_AW-1:0]   w_cell_waddr;
    logic [15:0]          w_cell_wdata;
    logic [CELL_AW-1:0]   w_cell_raddr;

    hva_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dims  (w_dims)
    );

    hva_ram #(
        .WIDTH (20),
        .DEPTH (hva_pkg::TAB_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr ({r_sl, w_fill[BW-1:0]}),
        .i_wdata (r_entry),
        .i_raddr ({r_sl, r_idx}),
        .o_rdata (w_tab_rdata)
    );

    hva_ram #(
        .WIDTH (FW),
        .DEPTH (hva_pkg::NUM_SLICES)
    ) u_fill (
        .i_clk   (i_clk),
        .i_we    (w_fill_we),
        .i_waddr (r_sl),
        .i_wdata (w_fill + FW'(1)),
        .i_raddr (r_sl),
        .o_rdata (w_fill_rdata)
    );

    hva_ram #(
        .WIDTH (16),
        .DEPTH (hva_pkg::CELL_DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_cell_we),
        .i_waddr (w_cell_waddr),
        .i_wdata (w_cell_wdata),
        .i_raddr (w_cell_raddr),
        .o_rdata (w_cell_rdata)
    );

    hva_vote_unit u_unit (
        .i_px    (r_px),
        .i_py    (r_py),
        .i_entry (w_tab_rdata),
        .i_dims  (w_dims),
        .i_count (w_cell_rdata),
        .i_best  (r_best_cnt),
        .o_eval  (w_eval)
    );

    assign w_in_slice    = s_axis_tdata[23:18];
    assign w_fill        = r_fill_vld[r_sl] ? w_fill_rdata : '0;
    assign w_full        = w_fill >= FW'(hva_pkg::BUCKET_DEPTH);
    assign w_last        = (FW'(r_idx) + FW'(1)) == r_count;
    assign w_cell_raddr  = {r_cy[YW-1:0], r_cx[XW-1:0]};
    assign s_axis_tready = (r_state == hva_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {7'd0, r_out_bh, r_out_by, r_out_bx, r_out_cast};

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_px         = r_px;
        n_py         = r_py;
        n_sl         = r_sl;
        n_sl_ok      = r_sl_ok;
        n_entry      = r_entry;
        n_count      = r_count;
        n_idx        = r_idx;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_status     = r_status;
        n_cast       = r_cast;
        n_best_x     = r_best_x;
        n_best_y     = r_best_y;
        n_best_cnt   = r_best_cnt;
        n_clr_addr   = r_clr_addr;
        n_clr_item   = r_clr_item;
        n_fill_vld   = r_fill_vld;
        n_out_vld    = r_out_vld && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_cast   = r_out_cast;
        n_out_bx     = r_out_bx;
        n_out_by     = r_out_by;
        n_out_bh     = r_out_bh;
        w_tab_we     = 1'b0;
        w_fill_we    = 1'b0;
        w_cell_we    = 1'b0;
        w_cell_waddr = w_cell_raddr;
        w_cell_wdata = w_eval.next_count;

        case (r_state)
            hva_pkg::ST_CLEAR: begin
                w_cell_we    = 1'b1;
                w_cell_waddr = r_clr_addr;
                w_cell_wdata = '0;
                n_clr_addr   = r_clr_addr + CELL_AW'(1);
                if (r_clr_addr == '1) begin
                    n_state = r_clr_item ? hva_pkg::ST_DONE : hva_pkg::ST_IDLE;
                end
            end
            hva_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode   = hva_pkg::t_mode'(s_axis_tuser);
                    n_px     = s_axis_tdata[8:0];
                    n_py     = s_axis_tdata[17:9];
                    n_sl     = SLW'(w_in_slice);
                    n_sl_ok  = 32'(w_in_slice) < hva_pkg::NUM_SLICES;
                    n_entry  = s_axis_tdata[43:24];
                    n_status = 1'b0;
                    n_cast   = '0;
                    case (hva_pkg::t_mode'(s_axis_tuser))
                        hva_pkg::MODE_CLR_VOTES: begin
                            n_clr_item = 1'b1;
                            n_clr_addr = '0;
                            n_best_x   = '0;
                            n_best_y   = '0;
                            n_best_cnt = '0;
                            n_state    = hva_pkg::ST_CLEAR;
                        end
                        hva_pkg::MODE_CLR_TABLE: begin
                            n_fill_vld = '0;
                            n_state    = hva_pkg::ST_DONE;
                        end
                        default: begin
                            n_state = hva_pkg::ST_FILL_RD;
                        end
                    endcase
                end
            end
            hva_pkg::ST_FILL_RD: begin
                n_state = hva_pkg::ST_FILL_DAT;
            end
            hva_pkg::ST_FILL_DAT: begin
                n_count = w_fill;
                n_idx   = '0;
                if (r_mode == hva_pkg::MODE_LOAD) begin
                    n_state = hva_pkg::ST_DONE;
                    if (!r_sl_ok || w_full) begin
                        n_status = 1'b1;
                    end else begin
                        w_tab_we         = 1'b1;
                        w_fill_we        = 1'b1;
                        n_fill_vld[r_sl] = 1'b1;
                    end
                end else if (!r_sl_ok || (w_fill == '0)) begin
                    n_state = hva_pkg::ST_DONE;
                end else begin
                    n_state = hva_pkg::ST_TAB_RD;
                end
            end
            hva_pkg::ST_TAB_RD: begin
                n_state = hva_pkg::ST_TAB_DAT;
            end
            hva_pkg::ST_TAB_DAT: begin
                n_cx = w_eval.cx;
                n_cy = w_eval.cy;
                if (w_eval.in_image) begin
                    n_state = hva_pkg::ST_CELL_RD;
                end else begin
                    n_idx   = r_idx + BW'(1);
                    n_state = w_last ? hva_pkg::ST_DONE : hva_pkg::ST_TAB_RD;
                end
            end
            hva_pkg::ST_CELL_RD: begin
                n_state = hva_pkg::ST_CELL_DAT;
            end
            hva_pkg::ST_CELL_DAT: begin
                w_cell_we = 1'b1;
                n_cast    = r_cast + 7'd1;
                if (w_eval.beats_best) begin
                    n_best_cnt = w_eval.next_count;
                    n_best_x   = r_cx[8:0];
                    n_best_y   = r_cy[8:0];
                end
                n_idx   = r_idx + BW'(1);
                n_state = w_last ? hva_pkg::ST_DONE : hva_pkg::ST_TAB_RD;
            end
            hva_pkg::ST_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_status;
                    n_out_cast   = r_cast;
                    n_out_bx     = r_best_x;
                    n_out_by     = r_best_y;
                    n_out_bh     = r_best_cnt;
                    n_state      = hva_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hva_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= hva_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_clr_item <= 1'b0;
            r_fill_vld <= '0;
            r_best_x   <= '0;
            r_best_y   <= '0;
            r_best_cnt <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_clr_item <= n_clr_item;
            r_fill_vld <= n_fill_vld;
            r_best_x   <= n_best_x;
            r_best_y   <= n_best_y;
            r_best_cnt <= n_best_cnt;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_px         <= n_px;
        r_py         <= n_py;
        r_sl         <= n_sl;
        r_sl_ok      <= n_sl_ok;
        r_entry      <= n_entry;
        r_count      <= n_count;
        r_idx        <= n_idx;
        r_cx         <= n_cx;
        r_cy         <= n_cy;
        r_status     <= n_status;
        r_cast       <= n_cast;
        r_out_status <= n_out_status;
        r_out_cast   <= n_out_cast;
        r_out_bx     <= n_out_bx;
        r_out_by     <= n_out_by;
        r_out_bh     <= n_out_bh;
    end

endmodule

FILE: test/hva_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hva_checker
// Watches the item, result and register channels of the Hough vote
// accumulator. It keeps its own R-table, accumulator and best cell, predicts
// the result of every accepted item and compares each accepted result with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module hva_checker
    import hva_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [47:0] i_item_tdata,
    input  logic [1:0]  i_item_tuser,
    input  logic        i_item_tvalid,
    input  logic        i_item_tready,
    input  logic [47:0] i_res_tdata,
    input  logic        i_res_tuser,
    input  logic        i_res_tvalid,
    input  logic        i_res_tready,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic        dropped;
        logic [6:0]  votes;
        logic [8:0]  best_x;
        logic [8:0]  best_y;
        logic [15:0] best_hits;
    } t_tally;

    bit signed [9:0] rt_dx [NUM_SLICES][BUCKET_DEPTH];
    bit signed [9:0] rt_dy [NUM_SLICES][BUCKET_DEPTH];
    int              rt_fill [NUM_SLICES];
    bit [15:0]       cell_hits [CELL_DEPTH];
    int              lead_x;
    int              lead_y;
    int              lead_hits;
    int              img_w;
    int              img_h;
    t_tally          tally_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic void wipe_votes();
        foreach (cell_hits[k]) cell_hits[k] = '0;
        lead_x    = 0;
        lead_y    = 0;
        lead_hits = 0;
    endfunction

    function automatic t_tally tally_item(input t_mode mode, input int px, input int py,
                                          input int sl, input bit signed [9:0] ox,
                                          input bit signed [9:0] oy);
        t_tally t;
        int     w;
        int     h;
        int     cx;
        int     cy;
        int     idx;
        int     cast;
        t.dropped = 1'b0;
        cast = 0;
        case (mode)
            MODE_LOAD: begin
                if (sl >= NUM_SLICES || rt_fill[sl] >= BUCKET_DEPTH) begin
                    t.dropped = 1'b1;
                end else begin
                    rt_dx[sl][rt_fill[sl]] = ox;
                    rt_dy[sl][rt_fill[sl]] = oy;
                    rt_fill[sl]++;
                end
            end
            MODE_VOTE: begin
                if (sl < NUM_SLICES) begin
                    w = (img_w > MAX_WIDTH) ? MAX_WIDTH : img_w;
                    h = (img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h;
                    for (int i = 0; i < rt_fill[sl]; i++) begin
                        cx = px + int'(rt_dx[sl][i]);
                        cy = py + int'(rt_dy[sl][i]);
                        if (cx >= 0 && cx < w && cy >= 0 && cy < h) begin
                            idx = cy * MAX_WIDTH + cx;
                            if (cell_hits[idx] != COUNT_MAX) cell_hits[idx]++;
                            cast++;
                            if (int'(cell_hits[idx]) > lead_hits) begin
                                lead_hits = cell_hits[idx];
                                lead_x    = cx;
                                lead_y    = cy;
                            end
                        end
                    end
                end
            end
            MODE_CLR_VOTES: wipe_votes();
            default: foreach (rt_fill[k]) rt_fill[k] = 0;
        endcase
        t.votes     = 7'(cast);
        t.best_x    = 9'(lead_x);
        t.best_y    = 9'(lead_y);
        t.best_hits = 16'(lead_hits);
        return t;
    endfunction

    always @(posedge i_clk) begin
        t_tally want;
        if (!i_rst_n) begin
            foreach (rt_fill[k]) rt_fill[k] = 0;
            wipe_votes();
            img_w = 512;
            img_h = 512;
            tally_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_WIDTH) img_w = i_pwdata[9:0];
                else img_h = i_pwdata[9:0];
            end
            if (i_item_tvalid && i_item_tready) begin
                tally_q.insert(tally_q.size(),
                               tally_item(t_mode'(i_item_tuser), i_item_tdata[8:0],
                                          i_item_tdata[17:9], i_item_tdata[23:18],
                                          i_item_tdata[33:24], i_item_tdata[43:34]));
            end
            if (i_res_tvalid && i_res_tready) begin
                if (tally_q.size() == 0) begin
                    report_mismatch("unpredicted result, votes_cast", i_res_tdata[6:0], 0);
                end else begin
                    want = tally_q.pop_front();
                    if (i_res_tuser !== want.dropped)
                        report_mismatch("status", i_res_tuser, want.dropped);
                    if (i_res_tdata[6:0] !== want.votes)
                        report_mismatch("votes_cast", i_res_tdata[6:0], want.votes);
                    if (i_res_tdata[15:7] !== want.best_x)
                        report_mismatch("best_x", i_res_tdata[15:7], want.best_x);
                    if (i_res_tdata[24:16] !== want.best_y)
                        report_mismatch("best_y", i_res_tdata[24:16], want.best_y);
                    if (i_res_tdata[40:25] !== want.best_hits)
                        report_mismatch("best_hits", i_res_tdata[40:25], want.best_hits);
                end
            end
        end
        o_pending = tally_q.size();
    end

endmodule

FILE: test/tb_hough_vote_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hough_vote_accumulator
// Drives the Hough vote accumulator with a directed set of table loads, votes
// and clears, a run that fills one bucket and saturates one cell, and random
// traffic under several image sizes and idle patterns. The checker beside the
// block predicts and compares; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_hough_vote_accumulator;
    import hva_pkg::*;

    localparam int QUIET_LIMIT  = 1_100_000;
    localparam int PHASE_ITEMS  = 22;
    localparam int SAT_VOTES    = 1024;
    localparam int DRAIN_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    hough_vote_accumulator u_top (.*);

    hva_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_tdata  (s_axis_tdata),
        .i_item_tuser  (s_axis_tuser),
        .i_item_tvalid (s_axis_tvalid),
        .i_item_tready (s_axis_tready),
        .i_res_tdata   (m_axis_tdata),
        .i_res_tuser   (m_axis_tuser),
        .i_res_tvalid  (m_axis_tvalid),
        .i_res_tready  (m_axis_tready),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The clearing pass after reset or a vote clear is the longest quiet stretch.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(input t_mode mode, input int px, input int py, input int sl,
                             input int ox, input int oy);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {8'd0, 10'(oy), 10'(ox), 6'(sl), 9'(py), 9'(px)};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input int value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {22'($urandom), 10'(value)};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 40) return $urandom_range(64, 16);
        if (r < 60) return $urandom_range(1023);
        if (r < 80) return 512;
        if (r < 90) return 1;
        return 1023;
    endfunction

    function automatic int pick_offset();
        if ($urandom_range(1)) return int'($urandom_range(16)) - 8;
        return int'($urandom_range(1023)) - 512;
    endfunction

    function automatic int pick_pixel();
        if ($urandom_range(1)) return $urandom_range(31);
        return $urandom_range(511);
    endfunction

    task automatic send_random_item();
        int r;
        int sl;
        r  = $urandom_range(99);
        sl = ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(63);
        if (r < 3) begin
            send_item(MODE_CLR_TABLE, $urandom_range(511), $urandom_range(511), sl,
                      $urandom_range(1023), $urandom_range(1023));
        end else if (r < 48) begin
            send_item(MODE_LOAD, $urandom_range(511), $urandom_range(511), sl,
                      pick_offset(), pick_offset());
        end else begin
            send_item(MODE_VOTE, pick_pixel(), pick_pixel(), sl,
                      $urandom_range(1023), $urandom_range(1023));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = MODE_LOAD;
        s_axis_tvalid  = 1'b0;
        m_axis_tready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        quiet_cycles   = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Offsets at both extremes, votes at the image corners, an empty bucket.
        send_item(MODE_LOAD, 0, 0, 0, 0, 0);
        send_item(MODE_LOAD, 0, 0, 0, -512, -512);
        send_item(MODE_LOAD, 0, 0, 0, 511, 511);
        send_item(MODE_LOAD, 0, 0, 0, 5, -3);
        send_item(MODE_VOTE, 0, 0, 0, 0, 0);
        send_item(MODE_VOTE, 511, 511, 0, 0, 0);
        send_item(MODE_VOTE, 3, 3, 63, 0, 0);
        send_item(MODE_LOAD, 0, 0, 63, -300, 200);
        send_item(MODE_VOTE, 400, 10, 63, 0, 0);
        send_item(MODE_CLR_TABLE, 0, 0, 0, 0, 0);
        send_item(MODE_VOTE, 0, 0, 0, 0, 0);

        // A pixel outside a narrow image still votes into it.
        write_reg(REG_WIDTH, 100);
        write_reg(REG_HEIGHT, 1);
        send_item(MODE_LOAD, 0, 0, 1, -250, -7);
        send_item(MODE_VOTE, 300, 7, 1, 0, 0);
        send_item(MODE_VOTE, 300, 8, 1, 0, 0);

        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 1023);
        send_item(MODE_VOTE, 300, 7, 1, 0, 0);

        // Sizes above the maximum are clamped, so column 512 stays outside.
        write_reg(REG_WIDTH, 1023);
        send_item(MODE_LOAD, 0, 0, 1, 0, 0);
        send_item(MODE_VOTE, 511, 511, 1, 0, 0);
        send_item(MODE_LOAD, 0, 0, 2, 511, 511);
        send_item(MODE_VOTE, 1, 0, 2, 0, 0);

        // Fill one bucket, overflow it, then drive one cell into saturation.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(MODE_CLR_TABLE, 0, 0, 0, 0, 0);
        for (int i = 0; i < BUCKET_DEPTH; i++) send_item(MODE_LOAD, 0, 0, 9, 0, 0);
        send_item(MODE_LOAD, 0, 0, 9, 3, 3);
        for (int i = 0; i < SAT_VOTES; i++) send_item(MODE_VOTE, 7, 9, 9, 0, 0);
        send_item(MODE_CLR_VOTES, 0, 0, 0, 0, 0);
        send_item(MODE_VOTE, 7, 9, 9, 0, 0);
        send_item(MODE_CLR_TABLE, 0, 0, 0, 0, 0);

        // Vote clears are left out here: each one costs a full clearing pass.
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(REG_WIDTH, pick_dim());
            write_reg(REG_HEIGHT, pick_dim());
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/hva_pkg.sv
hdl/hva_ram.sv
hdl/hva_apb_regs.sv
hdl/hva_vote_unit.sv
hdl/hough_vote_accumulator.sv
test/hva_checker.sv
test/tb_hough_vote_accumulator.sv
